[rtl/knn_pkg.sv]
package knn_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int MAX_K      = 64;
    localparam int DIMS       = 4;
    localparam int COORD_BITS = 16;
    localparam int IN_COORDS  = 4;

    localparam int IDX_W   = $clog2(MAX_POINTS);
    localparam int CNT_W   = IDX_W + 1;
    localparam int KI_W    = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int K_W     = 7;
    localparam int DIM_W   = 3;
    localparam int CFG_W   = 7;
    localparam int DIFF_W  = COORD_BITS + 1;
    localparam int SQ_W    = 2 * COORD_BITS;
    localparam int DIST_W  = SQ_W + 3;
    localparam int OIDX_W  = 10;
    localparam int ODIST_W = 34;
    localparam int LIM_D   = (DIMS < IN_COORDS) ? DIMS : IN_COORDS;
    localparam int PT_W    = DIMS * COORD_BITS;

    typedef enum logic [1:0] {
        FUNC_CLEAR = 2'd0,
        FUNC_ADD   = 2'd1,
        FUNC_QUERY = 2'd2,
        FUNC_NONE  = 2'd3
    } t_func;

    localparam logic CFG_NEIGHBOR_COUNT = 1'b0;
    localparam logic CFG_DIMS_IN_USE    = 1'b1;

    typedef logic [DIST_W-1:0] t_dist;
    typedef logic [IDX_W-1:0]  t_idx;

    // one candidate entering the sorted list
    typedef struct packed {
        logic  v;
        t_dist dsq;
        t_idx  idx;
    } t_cand;

endpackage

[rtl/knn_req_if.sv]
interface knn_req_if;
    import knn_pkg::*;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   func;
    logic signed [COORD_BITS-1:0] coord_0;
    logic signed [COORD_BITS-1:0] coord_1;
    logic signed [COORD_BITS-1:0] coord_2;
    logic signed [COORD_BITS-1:0] coord_3;

    modport source(output valid, func, coord_0, coord_1, coord_2, coord_3, input ready);
    modport sink(input valid, func, coord_0, coord_1, coord_2, coord_3, output ready);
endinterface

[rtl/knn_res_if.sv]
interface knn_res_if;
    import knn_pkg::*;
    logic               valid;
    logic               ready;
    logic [OIDX_W-1:0]  point_index;
    logic [ODIST_W-1:0] distance_sq;
    logic               last_of_run;
    logic               none_stored;

    modport source(output valid, point_index, distance_sq, last_of_run, none_stored,
                   input ready);
    modport sink(input valid, point_index, distance_sq, last_of_run, none_stored,
                 output ready);
endinterface

[rtl/k_nearest_neighbor_search.sv]
// Requests are taken only while idle and no result is held in the output register; under
// that condition a result-free request is taken every cycle. A query scans every stored
// point through a read, difference, square and sum pipeline fed by the single read port of
// the point memory, then gives one result per cycle (up to k) through the output register
// while the sink is ready. Synchronous active-low reset empties the store, sets k to 1 and
// dims_in_use to 2; the point memory itself is not cleared.
module k_nearest_neighbor_search
    import knn_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [CFG_W-1:0]   i_cfg_data,
    knn_req_if.sink            i_req,
    knn_res_if.source          o_res
);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_EMIT} t_state;

    t_state                 r_state;
    logic [K_W-1:0]         r_k;
    logic [DIM_W-1:0]       r_dims;
    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       r_issue;
    logic [PT_W-1:0]        r_mem [MAX_POINTS];
    logic [PT_W-1:0]        r_rdata;
    logic [PT_W-1:0]        r_query;
    logic [DIM_W-1:0]       r_deff;
    logic [KI_W-1:0]        r_k_m1;
    logic                   r_v1, r_v2, r_v3, r_v4;
    t_idx                   r_idx1, r_idx2, r_idx3, r_idx4;
    logic signed [DIFF_W-1:0] r_diff [DIMS];
    logic [SQ_W-1:0]        r_sq [DIMS];
    t_dist                  r_dist;
    logic                   r_out_valid;
    logic [OIDX_W-1:0]      r_out_idx;
    logic [ODIST_W-1:0]     r_out_dist;
    logic                   r_out_last;
    logic                   r_out_none;

    logic [PT_W-1:0]        in_pt;
    logic                   acc;
    logic                   issue;
    logic                   load;
    logic                   pop;
    logic [K_W-1:0]         k_eff;
    logic [DIM_W-1:0]       d_eff;
    t_cand                  cand;
    t_dist                  head_dist;
    t_idx                   head_idx;
    logic                   head_last;
    t_dist                  n_dist;

    assign in_pt = {i_req.coord_3, i_req.coord_2, i_req.coord_1, i_req.coord_0};
    assign i_req.ready = (r_state == S_IDLE) && !r_out_valid;
    assign acc   = i_req.valid && i_req.ready;
    assign issue = (r_state == S_SCAN) && (r_issue < r_count);
    assign load  = (r_state == S_EMIT) && (!r_out_valid || o_res.ready);
    assign pop   = load;

    // saturate k and dims to their legal ranges
    always_comb begin
        k_eff = r_k;
        if (r_k == '0) k_eff = K_W'(1);
        if (r_k > K_W'(MAX_K)) k_eff = K_W'(MAX_K);
        d_eff = r_dims;
        if (r_dims == '0) d_eff = DIM_W'(1);
        if (r_dims > DIM_W'(LIM_D)) d_eff = DIM_W'(LIM_D);
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k    <= K_W'(1);
            r_dims <= DIM_W'(2);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_NEIGHBOR_COUNT: r_k    <= i_cfg_data[K_W-1:0];
                CFG_DIMS_IN_USE:    r_dims <= i_cfg_data[DIM_W-1:0];
                default:            r_k    <= r_k;
            endcase
        end
    end

    // point memory: append on add while not full, one read per scan cycle while points remain to issue
    always_ff @(posedge i_clk) begin
        if (acc && i_req.func == FUNC_ADD && r_count < CNT_W'(MAX_POINTS)) begin
            r_mem[r_count[IDX_W-1:0]] <= in_pt;
        end
        if (issue) begin
            r_rdata <= r_mem[r_issue[IDX_W-1:0]];
        end
    end

    // sequencer and store count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_issue <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        case (i_req.func)
                            FUNC_CLEAR: r_count <= '0;
                            FUNC_ADD: begin
                                if (r_count < CNT_W'(MAX_POINTS)) r_count <= r_count + 1'b1;
                            end
                            FUNC_QUERY: begin
                                if (r_count != '0) begin
                                    r_state <= S_SCAN;
                                    r_issue <= '0;
                                end
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_SCAN: begin
                    if (issue) begin
                        r_issue <= r_issue + 1'b1;
                    end else if (!r_v1 && !r_v2 && !r_v3 && !r_v4) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (load && head_last) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // query latch
    always_ff @(posedge i_clk) begin
        if (acc && i_req.func == FUNC_QUERY) begin
            r_query <= in_pt;
            r_deff  <= d_eff;
            r_k_m1  <= KI_W'(k_eff - 1'b1);
        end
    end

    // pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // distance stages: difference, square, sum
    always_comb begin
        n_dist = '0;
        for (int j = 0; j < DIMS; j++) begin
            n_dist = n_dist + DIST_W'(r_sq[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx1 <= r_issue[IDX_W-1:0];
        r_idx2 <= r_idx1;
        r_idx3 <= r_idx2;
        r_idx4 <= r_idx3;
        for (int j = 0; j < DIMS; j++) begin
            if (DIM_W'(j) < r_deff) begin
                r_diff[j] <= DIFF_W'(signed'(r_rdata[j*COORD_BITS +: COORD_BITS]))
                           - DIFF_W'(signed'(r_query[j*COORD_BITS +: COORD_BITS]));
            end else begin
                r_diff[j] <= '0;
            end
            r_sq[j] <= SQ_W'(r_diff[j] * r_diff[j]);
        end
        r_dist <= n_dist;
    end

    assign cand.v    = r_v4;
    assign cand.dsq  = r_dist;
    assign cand.idx  = r_idx4;

    knn_best u_best (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (acc),
        .i_k_m1      (r_k_m1),
        .i_cand      (cand),
        .i_pop       (pop),
        .o_head_dist (head_dist),
        .o_head_idx  (head_idx),
        .o_head_last (head_last)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load || (acc && i_req.func == FUNC_QUERY && r_count == '0)) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_idx  <= OIDX_W'(head_idx);
            r_out_dist <= head_dist[ODIST_W-1:0];
            r_out_last <= head_last;
            r_out_none <= 1'b0;
        end else if (acc) begin
            r_out_idx  <= '0;
            r_out_dist <= '0;
            r_out_last <= 1'b1;
            r_out_none <= 1'b1;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.point_index = r_out_idx;
    assign o_res.distance_sq = r_out_dist;
    assign o_res.last_of_run = r_out_last;
    assign o_res.none_stored = r_out_none;

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_POINTS))
        else $error("store count beyond capacity");

    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_issue <= r_count))
        else $error("scan address past store");

    a_emit_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (!r_v1 && !r_v2 && !r_v3 && !r_v4))
        else $error("emit while distance pipeline busy");

endmodule

[rtl/knn_best.sv]
// Sorted list of the k best candidates, one cell per rank.
module knn_best
    import knn_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_clear,
    input  logic [KI_W-1:0] i_k_m1,
    input  t_cand           i_cand,
    input  logic            i_pop,
    output t_dist           o_head_dist,
    output t_idx            o_head_idx,
    output logic            o_head_last
);

    t_dist              r_dist [MAX_K];
    t_idx               r_idx  [MAX_K];
    logic [MAX_K-1:0]   r_valid;

    logic [MAX_K-1:0]   lt;
    logic [MAX_K-1:0]   prev_lt;
    logic [MAX_K-1:0]   valid_sh;
    logic               full;
    logic               ins;

    // a cell ranks behind the candidate when empty or strictly farther
    always_comb begin
        for (int p = 0; p < MAX_K; p++) begin
            lt[p] = !r_valid[p] || (i_cand.dsq < r_dist[p]);
        end
        prev_lt[0] = 1'b0;
        for (int p = 1; p < MAX_K; p++) begin
            prev_lt[p] = lt[p-1];
        end
        full     = r_valid[i_k_m1];
        ins      = i_cand.v && (!full || lt[i_k_m1]);
        valid_sh = r_valid >> 1;
    end

    // control: thermometer of filled cells
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_valid <= '0;
        end else if (i_pop) begin
            r_valid <= valid_sh;
        end else if (ins && !full) begin
            r_valid <= (r_valid << 1) | {{(MAX_K-1){1'b0}}, 1'b1};
        end
    end

    // payload: insert with shift, or pop toward the head
    always_ff @(posedge i_clk) begin
        if (i_pop) begin
            for (int p = 0; p < MAX_K - 1; p++) begin
                r_dist[p] <= r_dist[p+1];
                r_idx[p]  <= r_idx[p+1];
            end
        end else if (ins) begin
            for (int p = 0; p < MAX_K; p++) begin
                if (lt[p]) begin
                    if (!prev_lt[p]) begin
                        r_dist[p] <= i_cand.dsq;
                        r_idx[p]  <= i_cand.idx;
                    end else begin
                        r_dist[p] <= r_dist[p-1];
                        r_idx[p]  <= r_idx[p-1];
                    end
                end
            end
        end
    end

    assign o_head_dist = r_dist[0];
    assign o_head_idx  = r_idx[0];
    assign o_head_last = !valid_sh[0];

    a_thermo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_valid + 1'b1) & r_valid) == '0)
        else $error("best list valid bits not contiguous");

    a_no_both: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !i_cand.v)
        else $error("pop during insert");

    a_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |=> (r_valid == $past(r_valid)) || $past(i_pop) || $past(i_clear))
        else $error("list grew beyond k");

endmodule

[tb/tb_top.sv]
module tb_top;
    import knn_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic i_cfg_idx = 1'b0;
    logic [CFG_W-1:0] i_cfg_data = '0;

    knn_req_if req_ch();
    knn_res_if res_ch();

    k_nearest_neighbor_search dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_req(req_ch.sink), .o_res(res_ch.source)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    typedef struct packed {
        t_func             func;
        logic signed [15:0] c0, c1, c2, c3;
    } t_point_req;

    typedef struct packed {
        logic [9:0]  idx;
        logic [33:0] dsq;
        logic        last;
        logic        none;
    } t_neighbor;

    t_point_req pending_reqs[$];
    t_neighbor  expected_neighbors[$];

    // predictor state
    logic signed [15:0] store_pts[MAX_POINTS][4];
    int unsigned n_stored = 0;
    int unsigned k_reg = 1;
    int unsigned dims_reg = 2;

    int err_count = 0;
    int idle_cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_off = 0;
    bit source_paused = 0;

    function automatic logic [63:0] point_dist(int unsigned p, t_point_req r);
        logic [63:0] sum;
        logic signed [17:0] diff;
        logic signed [15:0] q[4];
        int unsigned d;
        q[0] = r.c0; q[1] = r.c1; q[2] = r.c2; q[3] = r.c3;
        d = (dims_reg == 0) ? 1 : (dims_reg > 4 ? 4 : dims_reg);
        sum = '0;
        for (int j = 0; j < d; j++) begin
            diff = 18'(store_pts[p][j]) - 18'(q[j]);
            sum += 64'(diff * diff);
        end
        return sum;
    endfunction

    // model one accepted request
    task automatic predict_neighbors(t_point_req r);
        logic [63:0] bd[MAX_K];
        int unsigned bi[MAX_K];
        int unsigned k, filled, pos;
        logic [63:0] cur_dsq;
        t_neighbor nb;
        case (r.func)
            FUNC_CLEAR: n_stored = 0;
            FUNC_ADD: begin
                if (n_stored < MAX_POINTS) begin
                    store_pts[n_stored][0] = r.c0; store_pts[n_stored][1] = r.c1;
                    store_pts[n_stored][2] = r.c2; store_pts[n_stored][3] = r.c3;
                    n_stored++;
                end
            end
            FUNC_QUERY: begin
                if (n_stored == 0) begin
                    nb = '{idx: '0, dsq: '0, last: 1'b1, none: 1'b1};
                    expected_neighbors.push_back(nb);
                end else begin
                    k = (k_reg == 0) ? 1 : (k_reg > MAX_K ? MAX_K : k_reg);
                    if (k > n_stored) k = n_stored;
                    filled = 0;
                    for (int unsigned i = 0; i < n_stored; i++) begin
                        cur_dsq = point_dist(i, r);
                        if (filled == k && cur_dsq >= bd[k-1]) continue;
                        pos = (filled < k) ? filled : k - 1;
                        while (pos > 0 && bd[pos-1] > cur_dsq) begin
                            bd[pos] = bd[pos-1]; bi[pos] = bi[pos-1]; pos--;
                        end
                        bd[pos] = cur_dsq; bi[pos] = i;
                        if (filled < k) filled++;
                    end
                    for (int unsigned i = 0; i < filled; i++) begin
                        nb = '{idx: bi[i][9:0], dsq: bd[i][33:0],
                               last: (i + 1 == filled), none: 1'b0};
                        expected_neighbors.push_back(nb);
                    end
                end
            end
            default: ;
        endcase
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else if (!req_ch.valid || req_ch.ready) begin
            if (req_ch.valid) predict_neighbors(t_point_req'({req_ch.func, req_ch.coord_0,
                req_ch.coord_1, req_ch.coord_2, req_ch.coord_3}));
            if (pending_reqs.size() > 0 && !source_paused
                    && $urandom_range(99) >= send_idle_pct) begin
                t_point_req r;
                r = pending_reqs.pop_front();
                req_ch.valid <= 1'b1;
                req_ch.func <= r.func;
                req_ch.coord_0 <= r.c0; req_ch.coord_1 <= r.c1;
                req_ch.coord_2 <= r.c2; req_ch.coord_3 <= r.c3;
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // result monitor and sink stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                t_neighbor got, want;
                got = '{idx: res_ch.point_index, dsq: res_ch.distance_sq,
                        last: res_ch.last_of_run, none: res_ch.none_stored};
                if (expected_neighbors.size() == 0) begin
                    $display("%0t unexpected result: actual %p", $time, got);
                    err_count++;
                end else begin
                    want = expected_neighbors.pop_front();
                    if (got != want) begin
                        $display("%0t mismatch: expected %p actual %p", $time, want, got);
                        err_count++;
                    end
                end
            end
            if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // watchdog on acceptances
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 400000) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic t_point_req rand_req(t_func f, int span);
        t_point_req r;
        r.func = f;
        if (span == 0) begin
            r.c0 = 16'($urandom); r.c1 = 16'($urandom);
            r.c2 = 16'($urandom); r.c3 = 16'($urandom);
        end else begin
            r.c0 = 16'(int'($urandom_range(2*span)) - span);
            r.c1 = 16'(int'($urandom_range(2*span)) - span);
            r.c2 = 16'(int'($urandom_range(2*span)) - span);
            r.c3 = 16'(int'($urandom_range(2*span)) - span);
        end
        return r;
    endfunction

    task automatic push(t_func f, int span);
        pending_reqs.push_back(rand_req(f, span));
    endtask

    task automatic drain();
        wait (pending_reqs.size() == 0);
        @(posedge i_clk);
        while (req_ch.valid || expected_neighbors.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, int unsigned val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= CFG_W'(val);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_NEIGHBOR_COUNT) k_reg = val; else dims_reg = val;
    endtask

    // random mix: mostly adds then queries, some clears and unused codes
    task automatic random_phase(int n, int s_pct, int r_pct);
        int pick;
        send_idle_pct = s_pct; recv_stall_pct = r_pct;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(99);
            if (pick < 55) push(FUNC_ADD, ($urandom_range(3) == 0) ? 0 : 50);
            else if (pick < 90) push(FUNC_QUERY, ($urandom_range(3) == 0) ? 0 : 50);
            else if (pick < 95) push(FUNC_CLEAR, 0);
            else push(FUNC_NONE, 0);
        end
        drain();
    endtask

    initial begin
        t_point_req r;
        req_ch.valid = 1'b0; req_ch.func = FUNC_NONE;
        req_ch.coord_0 = '0; req_ch.coord_1 = '0; req_ch.coord_2 = '0; req_ch.coord_3 = '0;
        res_ch.ready = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty store, extremes, ties, unused code, clear
        push(FUNC_QUERY, 0);
        r = '{func: FUNC_ADD, c0: 16'sh7fff, c1: 16'sh7fff, c2: 16'sh7fff, c3: 16'sh7fff};
        pending_reqs.push_back(r);
        r = '{func: FUNC_ADD, c0: 16'sh8000, c1: 16'sh8000, c2: 16'sh8000, c3: 16'sh8000};
        pending_reqs.push_back(r);
        r = '{func: FUNC_ADD, c0: 16'sh8000, c1: 16'sh8000, c2: 16'sh8000, c3: 16'sh8000};
        pending_reqs.push_back(r);
        r = '{func: FUNC_NONE, c0: 16'sh1234, c1: 0, c2: 0, c3: 0};
        pending_reqs.push_back(r);
        r = '{func: FUNC_QUERY, c0: 16'sh7fff, c1: 16'sh7fff, c2: 16'sh7fff, c3: 16'sh7fff};
        pending_reqs.push_back(r);
        r = '{func: FUNC_QUERY, c0: 16'sh8000, c1: 16'sh8000, c2: 16'sh8000, c3: 16'sh8000};
        pending_reqs.push_back(r);
        drain();
        write_reg(CFG_NEIGHBOR_COUNT, 64);
        write_reg(CFG_DIMS_IN_USE, 4);
        r = '{func: FUNC_QUERY, c0: 16'sh8000, c1: 16'sh7fff, c2: 16'sh8000, c3: 16'sh7fff};
        pending_reqs.push_back(r);
        push(FUNC_CLEAR, 0);
        push(FUNC_QUERY, 0);
        drain();
        write_reg(CFG_NEIGHBOR_COUNT, 0);
        write_reg(CFG_DIMS_IN_USE, 0);
        push(FUNC_ADD, 0); push(FUNC_ADD, 0); push(FUNC_QUERY, 0);
        drain();
        write_reg(CFG_NEIGHBOR_COUNT, 127);
        write_reg(CFG_DIMS_IN_USE, 7);
        push(FUNC_QUERY, 0);
        drain();

        // random phases across idle/stall profiles and settings
        write_reg(CFG_NEIGHBOR_COUNT, 5); write_reg(CFG_DIMS_IN_USE, 2);
        random_phase(60, 0, 0);
        write_reg(CFG_NEIGHBOR_COUNT, 1); write_reg(CFG_DIMS_IN_USE, 1);
        random_phase(40, 57, 0);
        write_reg(CFG_NEIGHBOR_COUNT, 64); write_reg(CFG_DIMS_IN_USE, 4);
        random_phase(40, 0, 57);
        write_reg(CFG_NEIGHBOR_COUNT, 12); write_reg(CFG_DIMS_IN_USE, 3);
        random_phase(40, 22, 22);

        // long sink hold-off while requests keep coming
        send_idle_pct = 0; recv_stall_pct = 0;
        hold_off = 3000;
        for (int i = 0; i < 15; i++) push(i % 3 == 2 ? FUNC_QUERY : FUNC_ADD, 0);
        drain();
        // sender pause until all results are back
        source_paused = 1;
        push(FUNC_QUERY, 50);
        while (expected_neighbors.size() != 0) @(posedge i_clk);
        source_paused = 0;
        drain();
        repeat (200) @(posedge i_clk);

        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

[k_nearest_neighbor_search.f]
rtl/knn_pkg.sv
rtl/knn_req_if.sv
rtl/knn_res_if.sv
rtl/knn_best.sv
rtl/k_nearest_neighbor_search.sv
tb/tb_top.sv
